// ===== rtl/core/pfl_pkg.sv =====
// Shared types and constants for the protobuf field locator.
// Used by the channel interfaces, the parse step and the top level.
`default_nettype none
package pfl_pkg;

  localparam int MAX_MSG_BYTES = 4096;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 13;
  localparam int FIELD_W = 32;
  localparam int STAT_W  = 2;
  localparam int WT_W    = 3;
  // key bits kept: wire type plus a 32-bit field number
  localparam int ACC_W   = WT_W + FIELD_W;
  localparam int GRP_W   = 4;
  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(9);

  localparam logic [STAT_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD    = 2'd2;

  localparam logic [WT_W-1:0] WT_VARINT = 3'd0;
  localparam logic [WT_W-1:0] WT_FIX64  = 3'd1;
  localparam logic [WT_W-1:0] WT_LEN    = 3'd2;
  localparam logic [WT_W-1:0] WT_FIX32  = 3'd5;

  localparam logic [LEN_W-1:0] FIX32_BYTES = LEN_W'(4);
  localparam logic [LEN_W-1:0] FIX64_BYTES = LEN_W'(8);

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_VALUE = 3'd1,
    PH_LEN   = 3'd2,
    PH_SKIP  = 3'd3,
    PH_BAD   = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]   pos;
    phase_t             phase;
    logic [ACC_W-1:0]   acc;
    logic               hi;     // varint has a set bit at or above bit LEN_W
    logic [GRP_W-1:0]   grp;    // index of the next 7-bit group
    logic [FIELD_W-1:0] field;
    logic [LEN_W-1:0]   skip;
  } pstate_t;

  localparam pstate_t PSTATE_RST = '{
    pos:   '0,
    phase: PH_KEY,
    acc:   '0,
    hi:    1'b0,
    grp:   '0,
    field: '0,
    skip:  '0
  };

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  payload_offset;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/pfl_in_if.sv =====
// Request channel: one message byte with the message length.
// Depends on pfl_pkg.
`default_nettype none
interface pfl_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfl_pkg::BYTE_W-1:0]  data_byte;
  logic [pfl_pkg::LEN_W-1:0]   msg_len;

  modport source (output valid, output data_byte, output msg_len, input ready);
  modport sink   (input valid, input data_byte, input msg_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pfl_out_if.sv =====
// Result channel: status, payload offset and payload length.
// Depends on pfl_pkg.
`default_nettype none
interface pfl_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfl_pkg::STAT_W-1:0]  status;
  logic [pfl_pkg::LEN_W-1:0]   payload_offset;
  logic [pfl_pkg::LEN_W-1:0]   payload_length;

  modport source (output valid, output status, output payload_offset,
                  output payload_length, input ready);
  modport sink   (input valid, input status, input payload_offset,
                  input payload_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pfl_parse.sv =====
// Combinational parse step: one byte against the current scan state.
// Produces the next scan state and at most one result. Depends on pfl_pkg.
`default_nettype none
module pfl_parse #(
  parameter int MAX_MSG_BYTES = pfl_pkg::MAX_MSG_BYTES
) (
  input  pfl_pkg::pstate_t             st,
  input  logic [pfl_pkg::BYTE_W-1:0]   data_byte,
  input  logic [pfl_pkg::LEN_W-1:0]    msg_len,
  input  logic [pfl_pkg::FIELD_W-1:0]  target_field,
  output pfl_pkg::pstate_t             st_next,
  output logic                         res_valid,
  output pfl_pkg::result_t             res
);

  logic [pfl_pkg::LEN_W-1:0] len_nz;
  logic [pfl_pkg::LEN_W-1:0] len_c;
  logic [pfl_pkg::LEN_W:0]   pos_inc;
  logic                      last;
  logic [pfl_pkg::LEN_W-1:0] rem;
  logic [6:0]                grp_bits;
  logic                      more;
  logic [pfl_pkg::ACC_W-1:0] placed;
  logic [pfl_pkg::ACC_W-1:0] acc_new;
  logic                      hi_new;
  logic                      vdone;
  logic                      vlong;
  logic                      len_over;
  logic [pfl_pkg::WT_W-1:0]  wt;

  always_comb begin
    len_nz  = (msg_len == '0) ? pfl_pkg::LEN_W'(1) : msg_len;
    len_c   = (int'(len_nz) > MAX_MSG_BYTES) ? pfl_pkg::LEN_W'(MAX_MSG_BYTES) : len_nz;
    pos_inc = {1'b0, st.pos} + (pfl_pkg::LEN_W+1)'(1);
    last    = pos_inc >= {1'b0, len_c};
    rem     = last ? '0 : (len_c - pos_inc[pfl_pkg::LEN_W-1:0]);

    grp_bits = data_byte[6:0];
    more     = data_byte[7];
    case (st.grp)
      4'd0:    placed = pfl_pkg::ACC_W'(grp_bits);
      4'd1:    placed = pfl_pkg::ACC_W'(grp_bits) << 7;
      4'd2:    placed = pfl_pkg::ACC_W'(grp_bits) << 14;
      4'd3:    placed = pfl_pkg::ACC_W'(grp_bits) << 21;
      4'd4:    placed = pfl_pkg::ACC_W'(grp_bits) << 28;
      default: placed = '0;
    endcase
    acc_new = st.acc | placed;
    // bits beyond the kept window only matter as "length too large"
    hi_new  = st.hi || (|acc_new[pfl_pkg::ACC_W-1:pfl_pkg::LEN_W])
           || ((st.grp >= 4'd5) && (st.grp < pfl_pkg::GRP_LAST) && (|grp_bits))
           || ((st.grp == pfl_pkg::GRP_LAST) && grp_bits[0]);
    vdone    = !more;
    vlong    = more && (st.grp == pfl_pkg::GRP_LAST);
    len_over = hi_new || (acc_new[pfl_pkg::LEN_W-1:0] > rem);
    wt       = acc_new[pfl_pkg::WT_W-1:0];

    st_next   = st;
    res_valid = 1'b0;
    res       = '{status: pfl_pkg::ST_FOUND, payload_offset: '0, payload_length: '0};

    case (st.phase)
      pfl_pkg::PH_KEY, pfl_pkg::PH_VALUE, pfl_pkg::PH_LEN: begin
        st_next.acc = acc_new;
        st_next.hi  = hi_new;
        st_next.grp = st.grp + pfl_pkg::GRP_W'(1);
        if (vlong) begin
          st_next.phase = pfl_pkg::PH_BAD;
        end else if (vdone) begin
          st_next.acc = '0;
          st_next.hi  = 1'b0;
          st_next.grp = '0;
          if (st.phase == pfl_pkg::PH_KEY) begin
            st_next.field = acc_new[pfl_pkg::ACC_W-1:pfl_pkg::WT_W];
            if (wt == pfl_pkg::WT_VARINT) begin
              st_next.phase = pfl_pkg::PH_VALUE;
            end else if (wt == pfl_pkg::WT_LEN) begin
              st_next.phase = pfl_pkg::PH_LEN;
            end else if (wt == pfl_pkg::WT_FIX32) begin
              st_next.skip  = pfl_pkg::FIX32_BYTES;
              st_next.phase = (rem < pfl_pkg::FIX32_BYTES) ? pfl_pkg::PH_BAD
                                                           : pfl_pkg::PH_SKIP;
            end else if (wt == pfl_pkg::WT_FIX64) begin
              st_next.skip  = pfl_pkg::FIX64_BYTES;
              st_next.phase = (rem < pfl_pkg::FIX64_BYTES) ? pfl_pkg::PH_BAD
                                                           : pfl_pkg::PH_SKIP;
            end else begin
              st_next.phase = pfl_pkg::PH_BAD;
            end
          end else if (st.phase == pfl_pkg::PH_VALUE) begin
            st_next.phase = pfl_pkg::PH_KEY;
          end else if (len_over) begin
            st_next.phase = pfl_pkg::PH_BAD;
          end else if (st.field == target_field) begin
            res_valid     = 1'b1;
            res           = '{status: pfl_pkg::ST_FOUND,
                              payload_offset: pos_inc[pfl_pkg::LEN_W-1:0],
                              payload_length: acc_new[pfl_pkg::LEN_W-1:0]};
            st_next.phase = pfl_pkg::PH_DONE;
          end else if (acc_new[pfl_pkg::LEN_W-1:0] == '0) begin
            st_next.phase = pfl_pkg::PH_KEY;
          end else begin
            st_next.skip  = acc_new[pfl_pkg::LEN_W-1:0];
            st_next.phase = pfl_pkg::PH_SKIP;
          end
        end
      end
      pfl_pkg::PH_SKIP: begin
        st_next.skip = st.skip - pfl_pkg::LEN_W'(1);
        if (st.skip <= pfl_pkg::LEN_W'(1)) begin
          st_next.skip  = '0;
          st_next.phase = pfl_pkg::PH_KEY;
        end
      end
      default: begin
        // bad or done: drop bytes until the message ends
      end
    endcase

    if (last) begin
      // a found result already answers this message
      if (st_next.phase != pfl_pkg::PH_DONE) begin
        res_valid = 1'b1;
        res = '{status: ((st_next.phase == pfl_pkg::PH_KEY) && (st_next.grp == '0))
                        ? pfl_pkg::ST_ABSENT : pfl_pkg::ST_BAD,
                payload_offset: '0, payload_length: '0};
      end
      st_next = pfl_pkg::PSTATE_RST;
    end else begin
      st_next.pos = pos_inc[pfl_pkg::LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/protobuf_field_locator_top.sv =====
// Protobuf field locator: request register, parse step, result register.
// Depends on pfl_pkg, pfl_in_if, pfl_out_if and pfl_parse.
//
// Usage:
//   in_ch carries one byte of an encoded message per request, with the
//   message's total length on every byte. Bytes of one message follow each
//   other; the next message starts right after the last byte.
//   out_ch carries at most one result per message: found (with payload
//   offset and length) as soon as the matching length varint completes,
//   otherwise absent or malformed on the message's last byte.
//   cfg_we/cfg_wdata write the target field number; write it only while
//   no request is in flight.
// Timing:
//   A request is registered at acceptance and parsed from the request
//   register; its result is registered in the output register.
//   One byte per cycle is sustained while out_ch does not stall; the scan
//   state is a single register updated by one parse step per byte.
// Reset clears the scan state, the valid bits of both registers and the target field.
// When out_ch stalls, a held result blocks only the parse step; if the
// request register is empty, one more request is taken, then in_ch stalls.
`default_nettype none
module protobuf_field_locator_top #(
  parameter int MAX_MSG_BYTES = pfl_pkg::MAX_MSG_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pfl_pkg::FIELD_W-1:0]  cfg_wdata,
  pfl_in_if.sink                       in_ch,
  pfl_out_if.source                    out_ch
);

  logic [pfl_pkg::FIELD_W-1:0] target_field;
  logic                        req_valid;
  logic [pfl_pkg::BYTE_W-1:0]  req_byte;
  logic [pfl_pkg::LEN_W-1:0]   req_len;
  pfl_pkg::pstate_t            st;
  pfl_pkg::pstate_t            st_next;
  logic                        step_res_valid;
  pfl_pkg::result_t            step_res;
  logic                        res_valid;
  pfl_pkg::result_t            res;
  logic                        advance;

  assign advance     = req_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_field <= '0;
    end else if (cfg_we) begin
      target_field <= cfg_wdata;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_byte <= in_ch.data_byte;
      req_len  <= in_ch.msg_len;
    end
  end

  pfl_parse #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_parse (
    .st           (st),
    .data_byte    (req_byte),
    .msg_len      (req_len),
    .target_field (target_field),
    .st_next      (st_next),
    .res_valid    (step_res_valid),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pfl_pkg::PSTATE_RST;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step_res_valid;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res_valid) begin
      res <= step_res;
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.status         = res.status;
  assign out_ch.payload_offset = res.payload_offset;
  assign out_ch.payload_length = res.payload_length;

endmodule
`default_nettype wire
